/* hdl/mvm_pkg.sv */
// mvm_pkg: shared constants, codes and types of the matrix vector multiply unit
// no dependencies; used by the interfaces and every module in hdl
`default_nettype none

package mvm_pkg;

  localparam int MaxSize  = 1024;
  localparam int IdxW     = $clog2(MaxSize);
  localparam int NumW     = IdxW + 1;
  localparam int SizeW    = 11;
  localparam int ValueW   = 16;
  localparam int ProdW    = 2 * ValueW;
  localparam int RowIdxW  = 10;
  localparam int SumW     = 42;
  localparam int OutDepth = 4;
  localparam int PtrW     = $clog2(OutDepth);
  localparam int CntW     = $clog2(OutDepth + 1);

  localparam logic [SizeW-1:0] SizeReset = 11'd1024;

  typedef enum logic {
    KindVector = 1'b0,
    KindMatrix = 1'b1
  } kind_e;

  typedef struct packed {
    logic            start;
    logic            row_end;
    logic [IdxW-1:0] row;
    logic            last_row;
  } ctl_t;

  typedef struct packed {
    logic [RowIdxW-1:0]     row_index;
    logic signed [SumW-1:0] row_sum;
    logic                   last_row;
  } res_t;

endpackage

`default_nettype wire

/* hdl/mvm_stream_if.sv */
// mvm_in_if and mvm_out_if: valid/ready channels for input and result words
// depends on mvm_pkg for field widths
`default_nettype none

interface mvm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [mvm_pkg::ValueW-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface mvm_out_if;
  logic                               valid;
  logic                               ready;
  logic [mvm_pkg::RowIdxW-1:0]        row_index;
  logic signed [mvm_pkg::SumW-1:0]    row_sum;
  logic                               last_row;

  modport source (output valid, output row_index, output row_sum, output last_row, input ready);
  modport sink (input valid, input row_index, input row_sum, input last_row, output ready);
endinterface

`default_nettype wire

/* hdl/mvm_vec_ram.sv */
// mvm_vec_ram: vector store, one write and one registered read port
// depends on mvm_pkg for depth and width
`default_nettype none

module mvm_vec_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [mvm_pkg::IdxW-1:0]      waddr_i,
  input  logic [mvm_pkg::ValueW-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [mvm_pkg::IdxW-1:0]      raddr_i,
  output logic [mvm_pkg::ValueW-1:0]    rdata_o
);

  logic [mvm_pkg::ValueW-1:0] mem [mvm_pkg::MaxSize];
  logic [mvm_pkg::ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/mvm_out_fifo.sv */
// mvm_out_fifo: small result queue in front of the output channel
// depends on mvm_pkg and mvm_out_if
`default_nettype none

module mvm_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  mvm_pkg::res_t                push_data_i,
  output logic [mvm_pkg::CntW-1:0]     count_o,
  output logic                         pop_o,
  mvm_out_if.source                    out_o
);

  mvm_pkg::res_t                store_q [mvm_pkg::OutDepth];
  logic [mvm_pkg::PtrW-1:0]     wr_ptr_q;
  logic [mvm_pkg::PtrW-1:0]     rd_ptr_q;
  logic [mvm_pkg::CntW-1:0]     cnt_q;
  logic                         pop_w;
  mvm_pkg::res_t                head_w;

  assign pop_w  = out_o.valid && out_o.ready;
  assign head_w = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_w) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_w})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.row_index = head_w.row_index;
  assign out_o.row_sum   = head_w.row_sum;
  assign out_o.last_row  = head_w.last_row;
  assign count_o         = cnt_q;
  assign pop_o           = pop_w;

endmodule

`default_nettype wire

/* hdl/matrix_vector_multiply_unit.sv */
// matrix_vector_multiply_unit: square matrix times vector in signed Q8.8, Q26.16 row sums
// depends on mvm_pkg, mvm_stream_if, mvm_vec_ram and mvm_out_fifo
//
// Vector words (kind 0) fill the vector store in order; matrix words (kind 1) follow
// row-major, and the last column of each row yields one result word with the row index,
// the exact row sum and a final-row flag. While ready is high the unit takes one word
// every cycle, vector or matrix alike: each matrix word does one read of the vector
// store, one 16x16 multiply and one 42-bit add in a three-stage pipeline; a row's result
// is pushed from the add stage. Results wait in a four-word queue; ready drops only when
// that queue plus the rows still in the pipeline reach four words, so the input stalls
// only while the result side holds back. matrix_size must be written only while the unit
// is idle, which is not enforced; zero acts as one and values above 1024 act as 1024.
`default_nettype none

module matrix_vector_multiply_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvm_pkg::SizeW-1:0]     cfg_wdata_i,
  mvm_in_if.sink                        item_i,
  mvm_out_if.source                     result_o
);

  localparam int CmpW = (mvm_pkg::SizeW > mvm_pkg::NumW) ? mvm_pkg::SizeW : mvm_pkg::NumW;

  logic [mvm_pkg::SizeW-1:0]      size_q;
  logic [mvm_pkg::IdxW-1:0]       load_q, load_d;
  logic [mvm_pkg::IdxW-1:0]       col_q, col_d;
  logic [mvm_pkg::IdxW-1:0]       row_q, row_d;

  logic                           s1_v_q;
  mvm_pkg::ctl_t                  s1_ctl_q;
  logic signed [mvm_pkg::ValueW-1:0] s1_value_q;
  logic                           s2_v_q;
  mvm_pkg::ctl_t                  s2_ctl_q;
  logic signed [mvm_pkg::ProdW-1:0] prod_q;
  logic signed [mvm_pkg::SumW-1:0]  acc_q;

  logic [CmpW-1:0]                size_ext_w;
  logic [mvm_pkg::NumW-1:0]       num_w;
  logic [mvm_pkg::NumW-1:0]       last_w;
  logic                           acc_w;
  logic                           is_vec_w;
  logic                           is_mat_w;
  logic [mvm_pkg::IdxW-1:0]       wr_pos_w;
  logic                           row_end_w;
  logic                           final_w;
  mvm_pkg::ctl_t                  ctl_w;
  logic [mvm_pkg::ValueW-1:0]     rd_data_w;
  logic signed [mvm_pkg::SumW-1:0] sum_w;
  logic                           push_w;
  mvm_pkg::res_t                  push_data_w;
  logic [mvm_pkg::CntW-1:0]       fifo_cnt_w;
  logic                           pop_w;
  logic [mvm_pkg::CntW-1:0]       occ_w;

  // active size, clamped to one..MaxSize
  assign size_ext_w = CmpW'(size_q);
  always_comb begin
    priority if (size_q == '0) begin
      num_w = mvm_pkg::NumW'(1);
    end else if (size_ext_w > CmpW'(mvm_pkg::MaxSize)) begin
      num_w = mvm_pkg::NumW'(mvm_pkg::MaxSize);
    end else begin
      num_w = mvm_pkg::NumW'(size_ext_w);
    end
  end
  assign last_w = num_w - 1'b1;

  assign occ_w = fifo_cnt_w + mvm_pkg::CntW'(s1_v_q && s1_ctl_q.row_end)
                            + mvm_pkg::CntW'(s2_v_q && s2_ctl_q.row_end);
  assign item_i.ready = (occ_w < mvm_pkg::CntW'(mvm_pkg::OutDepth));

  assign acc_w    = item_i.valid && item_i.ready;
  assign is_vec_w = acc_w && (item_i.kind == mvm_pkg::KindVector);
  assign is_mat_w = acc_w && (item_i.kind == mvm_pkg::KindMatrix);

  assign wr_pos_w  = ({1'b0, load_q} >= num_w) ? '0 : load_q;
  assign row_end_w = ({1'b0, col_q} >= last_w);
  assign final_w   = ({1'b0, row_q} >= last_w);

  always_comb begin
    load_d = load_q;
    col_d  = col_q;
    row_d  = row_q;
    if (is_vec_w) begin
      load_d = ({1'b0, wr_pos_w} >= last_w) ? '0 : wr_pos_w + 1'b1;
      col_d  = '0;
      row_d  = '0;
    end else if (is_mat_w) begin
      load_d = '0;
      if (row_end_w) begin
        col_d = '0;
        row_d = final_w ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  assign ctl_w.start    = (col_q == '0);
  assign ctl_w.row_end  = row_end_w;
  assign ctl_w.row      = row_q;
  assign ctl_w.last_row = final_w;

  mvm_vec_ram u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (is_vec_w),
    .waddr_i (wr_pos_w),
    .wdata_i (item_i.value),
    .re_i    (is_mat_w),
    .raddr_i (col_q),
    .rdata_o (rd_data_w)
  );

  assign sum_w = (s2_ctl_q.start ? '0 : acc_q) + mvm_pkg::SumW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= mvm_pkg::SizeReset;
      load_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
      s1_v_q   <= 1'b0;
      s1_ctl_q <= '0;
      s2_v_q   <= 1'b0;
      s2_ctl_q <= '0;
      acc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      load_q <= load_d;
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= is_mat_w;
      if (is_mat_w) begin
        s1_ctl_q <= ctl_w;
      end
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        s2_ctl_q <= s1_ctl_q;
      end
      if (s2_v_q) begin
        acc_q <= sum_w;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (is_mat_w) begin
      s1_value_q <= item_i.value;
    end
    if (s1_v_q) begin
      prod_q <= s1_value_q * $signed(rd_data_w);
    end
  end

  assign push_w                = s2_v_q && s2_ctl_q.row_end;
  assign push_data_w.row_index = mvm_pkg::RowIdxW'(s2_ctl_q.row);
  assign push_data_w.row_sum   = sum_w;
  assign push_data_w.last_row  = s2_ctl_q.last_row;

  mvm_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_w),
    .push_data_i (push_data_w),
    .count_o     (fifo_cnt_w),
    .pop_o       (pop_w),
    .out_o       (result_o)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_w <= mvm_pkg::CntW'(mvm_pkg::OutDepth))
    else $error("result queue reservation exceeded");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_w && !pop_w && (fifo_cnt_w == mvm_pkg::CntW'(mvm_pkg::OutDepth))))
    else $error("push into full result queue");

  a_vec_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_vec_w |=> (col_q == '0) && (row_q == '0))
    else $error("vector word did not clear matrix position");

  a_row_end_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_mat_w && row_end_w) |=> ##1 push_w)
    else $error("row end did not produce a result word");

endmodule

`default_nettype wire
